// File: hw/rtl/lpht_pkg.sv
// shared types, constants and the key hash of the linear probe hash table
package lpht_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;

  // default table size
  localparam int CAPACITY_DEF = 1024;

  // entry count saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // operation codes carried in the input tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // hash rounds, one per cycle
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] HASH_LAST = 3'd5;

  // home slot reduction steps: multiply, quotient, multiply back, correct
  localparam int MSTEP_W = 2;
  localparam logic [MSTEP_W-1:0] MOD_LAST = 2'd3;

  // hash round constants
  localparam logic [DATA_W-1:0] HC0 = 32'h7ed55d16;
  localparam logic [DATA_W-1:0] HC1 = 32'hc761c23c;
  localparam logic [DATA_W-1:0] HC2 = 32'h165667b1;
  localparam logic [DATA_W-1:0] HC3 = 32'hd3a2646c;
  localparam logic [DATA_W-1:0] HC4 = 32'hfd7046c5;
  localparam logic [DATA_W-1:0] HC5 = 32'hb55a4f09;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // result kinds
  typedef enum logic [1:0] {
    RES_DONE,
    RES_HIT,
    RES_FULL
  } res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic hash;
    logic mod;
    logic rd;
    logic adv;
    logic wr;
    logic clr;
    logic res_set;
    res_t res;
    logic out_load;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode;
    logic hash_last;
    logic mod_last;
    logic occ;
    logic key_eq;
    logic sweep_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

  // one round of the add/xor/shift key mix
  function automatic logic [DATA_W-1:0] hash_step(input logic [DATA_W-1:0] x,
                                                  input logic [STEP_W-1:0] idx);
    logic [DATA_W-1:0] y;
    unique case (idx)
      3'd0:    y = (x + HC0) + (x << 12);
      3'd1:    y = (x ^ HC1) ^ (x >> 19);
      3'd2:    y = (x + HC2) + (x << 5);
      3'd3:    y = (x + HC3) ^ (x << 9);
      3'd4:    y = (x + HC4) + (x << 3);
      3'd5:    y = (x ^ HC5) ^ (x >> 16);
      default: y = x;
    endcase
    return y;
  endfunction

endpackage

// File: hw/rtl/lpht_ram.sv
// generic simple dual port ram with registered read
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lpht_ctrl.sv
// sequencer for clear, hash, reduce and probe phases
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lpht_pkg::dp_sts_t   sts,
  output lpht_pkg::ctrl_cmd_t cmd
);
  import lpht_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_HASH;
      ST_HASH:  if (sts.hash_last) state_nxt = ST_MOD;
      ST_MOD:   if (sts.mod_last) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!sts.occ || sts.sweep_last ||
            (sts.mode == MODE_LOOKUP && sts.key_eq)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    cmd.res   = RES_DONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_HASH:  cmd.hash = 1'b1;
      ST_MOD:   cmd.mod = 1'b1;
      ST_READ:  cmd.rd = 1'b1;
      ST_CHECK: begin
        if (sts.mode == MODE_INSERT) begin
          // first free slot takes the pair, a full sweep refuses it
          if (!sts.occ) begin
            cmd.wr      = 1'b1;
            cmd.res_set = 1'b1;
          end else if (sts.sweep_last) begin
            cmd.res_set = 1'b1;
            cmd.res     = RES_FULL;
          end else begin
            cmd.adv = 1'b1;
          end
        end else begin
          // free slot or full sweep is a miss, equal key is a hit
          if (!sts.occ) begin
            cmd.res_set = 1'b1;
          end else if (sts.key_eq) begin
            cmd.res_set = 1'b1;
            cmd.res     = RES_HIT;
          end else if (sts.sweep_last) begin
            cmd.res_set = 1'b1;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      ST_DONE:  cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/lpht_dp.sv
// datapath: key mix, home slot reduction, slot memories and result register
module lpht_dp #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpht_pkg::ctrl_cmd_t cmd,
  output lpht_pkg::dp_sts_t   sts,
  input  logic [63:0]         in_tdata,
  input  logic                in_tuser,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [31:0]         out_tdata,
  output logic [1:0]          out_tuser
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W:0]   CAP_V    = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // scaled reciprocal floor(2^(32+IDX_W) / CAPACITY), below 2^33
  localparam logic [63:0]       RECIP_FULL = (64'd1 << (DATA_W + IDX_W)) / 64'(CAPACITY);
  localparam logic [DATA_W-1:0] RECIP_LO   = RECIP_FULL[DATA_W-1:0];
  localparam logic              RECIP_HI   = RECIP_FULL[DATA_W];

  // captured item
  logic              mode_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;

  // hash and home slot reduction
  logic [DATA_W-1:0]   h_r;
  logic [STEP_W-1:0]   step_r;
  logic [MSTEP_W-1:0]  mstep_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0]   quo_r;
  logic [IDX_W:0]      red_r;
  logic [2*DATA_W-1:0] prod_nxt;
  logic [DATA_W:0]     quo_sum;
  logic [DATA_W:0]     quo_shift;
  logic [DATA_W-1:0]   qc_lo;
  logic [DATA_W-1:0]   rdiff;
  logic [IDX_W:0]      red_sub;

  // probe position and count
  logic [IDX_W-1:0]  pos_r;
  logic [IDX_W-1:0]  probe_r;
  logic [IDX_W-1:0]  pos_next;

  // clear sweep and entry count
  logic [IDX_W-1:0]   clr_r;
  logic [COUNT_W-1:0] cnt_r;

  // results
  logic              res_hit_r, res_st_r;
  logic [DATA_W-1:0] res_fv_r;
  logic              out_vld_r, out_hit_r, out_st_r;
  logic [DATA_W-1:0] out_fv_r;

  // memory ports
  logic [2*DATA_W-1:0] slot_rd;
  logic [DATA_W-1:0]   rd_key, rd_val;
  logic                occ_rd;
  logic                occ_we;
  logic [IDX_W-1:0]    occ_waddr;

  // hash mod CAPACITY: 32 by 32 reciprocal product, quotient estimate that is
  // exact or one short, multiply back and subtract, then one correction
  assign prod_nxt  = (2*DATA_W)'(h_r) * (2*DATA_W)'(RECIP_LO);
  assign quo_sum   = {1'b0, prod_r[2*DATA_W-1:DATA_W]} + (RECIP_HI ? {1'b0, h_r} : '0);
  assign quo_shift = quo_sum >> IDX_W;
  assign qc_lo     = quo_r * DATA_W'(CAPACITY);
  assign rdiff     = h_r - qc_lo;
  assign red_sub   = (red_r >= CAP_V) ? (red_r - CAP_V) : red_r;

  // linear probe wraps at the table end
  assign pos_next = (pos_r == LAST_IDX) ? '0 : (pos_r + 1'b1);

  assign rd_key = slot_rd[DATA_W-1:0];
  assign rd_val = slot_rd[2*DATA_W-1:DATA_W];

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      key_r  <= in_tdata[DATA_W-1:0];
      val_r  <= in_tdata[2*DATA_W-1:DATA_W];
      h_r    <= in_tdata[DATA_W-1:0];
      step_r <= '0;
    end else if (cmd.hash) begin
      h_r    <= hash_step(h_r, step_r);
      step_r <= step_r + 1'b1;
      if (step_r == HASH_LAST) begin
        mstep_r <= '0;
      end
    end else if (cmd.mod) begin
      // each stage settles in the cycle after the one before it
      mstep_r <= mstep_r + 1'b1;
      prod_r  <= prod_nxt;
      quo_r   <= quo_shift[DATA_W-1:0];
      red_r   <= rdiff[IDX_W:0];
      if (mstep_r == MOD_LAST) begin
        pos_r   <= red_sub[IDX_W-1:0];
        probe_r <= '0;
      end
    end else if (cmd.adv) begin
      pos_r   <= pos_next;
      probe_r <= probe_r + 1'b1;
    end
    if (cmd.res_set) begin
      res_hit_r <= (cmd.res == RES_HIT);
      res_fv_r  <= (cmd.res == RES_HIT) ? rd_val : '0;
      res_st_r  <= (cmd.res == RES_FULL);
    end
    if (cmd.out_load) begin
      out_hit_r <= res_hit_r;
      out_fv_r  <= res_fv_r;
      out_st_r  <= res_st_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.wr && cnt_r != COUNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // key and value store
  lpht_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(CAPACITY)
  ) u_slot_ram (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(pos_r),
    .wdata({val_r, key_r}),
    .re   (cmd.rd),
    .raddr(pos_r),
    .rdata(slot_rd)
  );

  // occupancy store, swept to zero after reset
  assign occ_we    = cmd.wr | cmd.clr;
  assign occ_waddr = cmd.clr ? clr_r : pos_r;

  lpht_ram #(
    .WIDTH(1),
    .DEPTH(CAPACITY)
  ) u_occ_ram (
    .clk  (clk),
    .we   (occ_we),
    .waddr(occ_waddr),
    .wdata(cmd.wr),
    .re   (cmd.rd),
    .raddr(pos_r),
    .rdata(occ_rd)
  );

  // status to controller
  always_comb begin
    sts.mode       = mode_r;
    sts.hash_last  = (step_r == HASH_LAST);
    sts.mod_last   = (mstep_r == MOD_LAST);
    sts.occ        = occ_rd;
    sts.key_eq     = (rd_key == key_r);
    sts.sweep_last = (probe_r == LAST_IDX);
    sts.clr_last   = (clr_r == LAST_IDX);
    sts.out_free   = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_fv_r;
  assign out_tuser  = {out_st_r, out_hit_r};

endmodule

// File: hw/rtl/linear_probe_hash_table_unit.sv
// top level of the linear probe hash table
//
//  channel   dir  handshake            payload
//  in_*      in   in_tvalid/in_tready  tdata {entry_value, lookup_key}, tuser mode
//  out_*     out  out_tvalid/out_tready tdata found_value, tuser {status, hit}
//
// one word at a time: accept, key mix, reduce the hash to its home slot
// (reciprocal multiply, quotient, multiply back, correction), then a memory
// read and a check for each probed slot, then the load of the output register.
// after reset the occupancy memory is swept with in_tready low.
// a finished word waits in the output register; a new word is taken meanwhile,
// and its result holds in the done state until the output register frees.
module linear_probe_hash_table_unit #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: lookup_key [31:0], entry_value [63:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // in_tuser: mode [0]
  input  logic        in_tuser,
  // out_tdata: found_value [31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: hit [0], status [1]
  output logic [1:0]  out_tuser
);
  import lpht_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // controller
  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  lpht_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // an accepted word keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  // inserts only land in a free slot
  a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (!sts.occ && sts.mode == MODE_INSERT))
    else $error("write into occupied slot");

  // no words are taken during the clearing sweep
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> (!in_tready && !cmd.wr))
    else $error("activity during clear sweep");

  // output valid only rises on a result load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without result");

endmodule
